// ----- rtl/r64tlv_pkg.sv -----
// ============================================================================
// r64tlv_pkg: shared types and constants for the Route64 TLV decoder
// Transaction structs for both channels, the internal command record that
// travels from the classifier to the result formatter, and status codes.
// ============================================================================
package r64tlv_pkg;

    // Number of router mask bytes that follow the ID sequence byte.
    localparam int MASK_BYTES = 8;
    // Byte position value that marks a complete header.
    localparam int HDR_END    = MASK_BYTES + 1;
    localparam int POS_W      = 4;
    localparam int MASK_W     = 64;
    localparam int RID_W      = 6;

    // Depth of the queue between the classifier and the formatter.
    localparam int Q_DEPTH    = 4;
    localparam int QPTR_W     = $clog2(Q_DEPTH);
    localparam int QCNT_W     = $clog2(Q_DEPTH + 1);

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_TOO_SHORT = 2'd1;
    localparam logic [1:0] STATUS_MISMATCH  = 2'd2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic             entry_valid;
        logic [RID_W-1:0] rtr_idx;
        logic [1:0]       outgoing_quality;
        logic [1:0]       incoming_quality;
        logic [3:0]       link_cost;
        logic [7:0]       seq_id;
        logic             done_res;
        logic [1:0]       status;
    } t_out;

    // Classified transaction handed from the front to the back.
    typedef struct packed {
        logic             entry;
        logic             done;
        logic [RID_W-1:0] rid;
        logic [7:0]       route_byte;
        logic [7:0]       seq;
        logic [1:0]       status;
    } t_cmd;

endpackage

// ----- rtl/r64tlv_front.sv -----
// ============================================================================
// r64tlv_front: header parser and route byte classifier
// Tracks the byte position, captures the ID sequence and router mask, pairs
// each route byte with the next set mask bit and decides the final status.
// ============================================================================
module r64tlv_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  r64tlv_pkg::t_in      i_in_data,
    input  logic                 i_full,
    output logic                 o_in_stall,
    output logic                 o_push,
    output r64tlv_pkg::t_cmd     o_cmd
);

    logic [r64tlv_pkg::POS_W-1:0]  r_pos,  n_pos;
    logic [7:0]                    r_seq,  n_seq;
    logic [r64tlv_pkg::MASK_W-1:0] r_mask, n_mask;
    logic                          r_mm,   n_mm;

    logic                          accept;
    logic                          entry;
    logic [r64tlv_pkg::RID_W-1:0]  rid;
    logic [r64tlv_pkg::RID_W-1:0]  ins_idx;
    logic [r64tlv_pkg::RID_W-1:0]  clr_idx;
    logic [1:0]                    status;

    assign o_in_stall = i_full;
    assign accept     = i_in_valid && !i_full;

    // Lowest-numbered router whose mask bit is still set (router r is bit 63-r).
    always_comb begin
        rid = '0;
        for (int i = r64tlv_pkg::MASK_W - 1; i >= 0; i--) begin
            if (r_mask[r64tlv_pkg::MASK_W - 1 - i]) begin
                rid = r64tlv_pkg::RID_W'(i);
            end
        end
    end

    // Top bit of the slot that mask byte number r_pos fills.
    assign ins_idx = r64tlv_pkg::RID_W'(r64tlv_pkg::MASK_W - 1)
                   - r64tlv_pkg::RID_W'({r_pos - 1'b1, 3'b000});
    assign clr_idx = r64tlv_pkg::RID_W'(r64tlv_pkg::MASK_W - 1) - rid;

    always_comb begin
        n_pos  = r_pos;
        n_seq  = r_seq;
        n_mask = r_mask;
        n_mm   = r_mm;
        entry  = 1'b0;
        status = r64tlv_pkg::STATUS_OK;

        if (r_pos == '0) begin
            n_seq  = i_in_data.data_byte;
            n_mask = '0;
            n_mm   = 1'b0;
            n_pos  = r64tlv_pkg::POS_W'(1);
        end else if (r_pos < r64tlv_pkg::POS_W'(r64tlv_pkg::HDR_END)) begin
            n_mask[ins_idx -: 8] = r_mask[ins_idx -: 8] | i_in_data.data_byte;
            n_pos = r_pos + 1'b1;
        end else if (r_mask != '0) begin
            n_mask[clr_idx] = 1'b0;
            entry = 1'b1;
        end else begin
            n_mm = 1'b1;
        end

        if (i_in_data.last) begin
            if (n_pos < r64tlv_pkg::POS_W'(r64tlv_pkg::HDR_END)) begin
                status = r64tlv_pkg::STATUS_TOO_SHORT;
            end else if (n_mm || n_mask != '0) begin
                status = r64tlv_pkg::STATUS_MISMATCH;
            end else begin
                status = r64tlv_pkg::STATUS_OK;
            end
        end
    end

    assign o_push           = accept && (entry || i_in_data.last);
    assign o_cmd.entry      = entry;
    assign o_cmd.done       = i_in_data.last;
    assign o_cmd.rid        = entry ? rid : '0;
    assign o_cmd.route_byte = i_in_data.data_byte;
    assign o_cmd.seq        = n_seq;
    assign o_cmd.status     = status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_seq  <= '0;
            r_mask <= '0;
            r_mm   <= 1'b0;
        end else if (accept) begin
            if (i_in_data.last) begin
                r_pos  <= '0;
                r_seq  <= '0;
                r_mask <= '0;
                r_mm   <= 1'b0;
            end else begin
                r_pos  <= n_pos;
                r_seq  <= n_seq;
                r_mask <= n_mask;
                r_mm   <= n_mm;
            end
        end
    end

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= r64tlv_pkg::POS_W'(r64tlv_pkg::HDR_END))
        else $error("byte position beyond header end");

    a_fresh_tlv_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos == '0) |-> (r_mask == '0 && !r_mm))
        else $error("stale mask or mismatch flag at start of TLV");

    a_entry_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_cmd.entry) |-> (r_pos == r64tlv_pkg::POS_W'(r64tlv_pkg::HDR_END)))
        else $error("route entry produced before header completed");

endmodule

// ----- rtl/r64tlv_fifo.sv -----
// ============================================================================
// r64tlv_fifo: command queue between classifier and formatter
// Small register queue that lets the front keep taking bytes while the
// back waits on a stalled output.
// ============================================================================
module r64tlv_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  r64tlv_pkg::t_cmd i_push_data,
    input  logic             i_pop,
    output r64tlv_pkg::t_cmd o_pop_data,
    output logic             o_empty,
    output logic             o_full
);

    r64tlv_pkg::t_cmd                r_mem [r64tlv_pkg::Q_DEPTH];
    logic [r64tlv_pkg::QPTR_W-1:0]   r_wptr;
    logic [r64tlv_pkg::QPTR_W-1:0]   r_rptr;
    logic [r64tlv_pkg::QCNT_W-1:0]   r_count;

    assign o_empty    = (r_count == '0);
    assign o_full     = (r_count == r64tlv_pkg::QCNT_W'(r64tlv_pkg::Q_DEPTH));
    assign o_pop_data = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("pop from empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= r64tlv_pkg::QCNT_W'(r64tlv_pkg::Q_DEPTH))
        else $error("queue count out of range");

endmodule

// ----- rtl/r64tlv_back.sv -----
// ============================================================================
// r64tlv_back: result formatter and output register
// Takes classified transactions from the queue, splits route bytes into
// link qualities and cost, and holds each result until it is taken.
// ============================================================================
module r64tlv_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_empty,
    input  r64tlv_pkg::t_cmd i_cmd,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output r64tlv_pkg::t_out o_out_data
);

    logic             r_out_valid;
    r64tlv_pkg::t_out r_out;
    r64tlv_pkg::t_out n_out;

    assign o_pop = !i_empty && (!r_out_valid || !i_out_stall);

    always_comb begin
        n_out             = '0;
        n_out.entry_valid = i_cmd.entry;
        n_out.seq_id      = i_cmd.seq;
        n_out.done_res    = i_cmd.done;
        if (i_cmd.entry) begin
            n_out.rtr_idx          = i_cmd.rid;
            n_out.outgoing_quality = i_cmd.route_byte[7:6];
            n_out.incoming_quality = i_cmd.route_byte[5:4];
            n_out.link_cost        = i_cmd.route_byte[3:0];
        end
        if (i_cmd.done) begin
            n_out.status = i_cmd.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.entry_valid || r_out.done_res))
        else $error("result carries neither entry nor end of TLV");

    a_status_only_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.done_res) |-> (r_out.status == r64tlv_pkg::STATUS_OK))
        else $error("status reported on a result that does not end the TLV");

    a_no_entry_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.entry_valid) |-> (r_out.rtr_idx == '0 &&
            r_out.link_cost == '0))
        else $error("route fields set on result without entry");

endmodule

// ----- rtl/route64_tlv_decoder_top.sv -----
// A byte that yields a result is pushed into the queue and then popped into
// the output register; header bytes that are not last produce no result.
// Throughput: one byte per cycle unless the queue is full, set by a
// combinational priority encoder pairing a route byte with the next mask bit.
// Reset: i_rst_n is synchronous and active low; it empties the queue, drops
// any pending result and returns the parser to byte 0 of a new TLV.
// ============================================================================
// route64_tlv_decoder_top: byte-serial Route64 TLV value decoder
// Byte 0 carries the ID sequence, the next bytes form a 64-bit router mask,
// and each later byte is a route byte, decoded into a route entry while set mask bits remain.
// ============================================================================
module route64_tlv_decoder_top (
    input  logic             i_clk,
    input  logic             i_rst_n,
    // Input channel: one TLV value byte per transaction.
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  r64tlv_pkg::t_in  i_in_data,
    // Output channel: one decoded entry and/or end-of-TLV status per transaction.
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output r64tlv_pkg::t_out o_out_data
);

    // The front classifies every accepted byte and pushes a command only when
    // the byte yields a result: a paired route byte, or the last byte.
    logic             push;
    r64tlv_pkg::t_cmd push_cmd;

    // The queue decouples the front from a stalled output; the front stalls
    // the input only when the queue is full, which is a registered condition
    // and so never depends on the input valid.
    logic             pop;
    r64tlv_pkg::t_cmd pop_cmd;
    logic             q_empty;
    logic             q_full;

    r64tlv_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .i_full     (q_full),
        .o_in_stall (o_in_stall),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    r64tlv_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .i_pop       (pop),
        .o_pop_data  (pop_cmd),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    // The back drains the queue into an output register; it refills that
    // register in the same cycle its current transaction is taken.
    r64tlv_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (q_empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // An accepted last byte always pushes a command, so the end of every TLV
    // reaches the output.
    a_last_pushes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_in_data.last) |-> push)
        else $error("last byte accepted without a result");

    // A pushed command shows up as a result no sooner than the next cycle.
    a_out_follows_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(pop))
        else $error("result appeared without a queue pop");

    // Nothing is pushed while no byte is accepted.
    a_push_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (i_in_valid && !o_in_stall))
        else $error("command pushed without an accepted byte");

endmodule

// ----- dv/route64_tlv_decoder_checker.sv -----
`timescale 1ns / 100ps
// ============================================================================
// route64_tlv_decoder_checker: result predictor and scoreboard
// Watches both channels of the Route64 TLV decoder. Each accepted byte runs
// through a cycle-free model of the parser, and each result it causes is
// queued. Every accepted result is then compared field by field with the
// oldest queued result.
// ============================================================================
module route64_tlv_decoder_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_stall,
    input  r64tlv_pkg::t_in  i_in_data,
    input  logic             i_out_valid,
    input  logic             i_out_stall,
    input  r64tlv_pkg::t_out i_out_data,
    output int               o_fail_count,
    output int               o_pending
);

    // Parser state of the model.
    logic [r64tlv_pkg::POS_W-1:0]  tlv_pos;
    logic [7:0]                    tlv_seq;
    logic [r64tlv_pkg::MASK_W-1:0] tlv_mask;
    logic                          tlv_extra;

    r64tlv_pkg::t_out decoded_results_q[$];
    r64tlv_pkg::t_out seen_result;
    r64tlv_pkg::t_out want_result;
    int               mismatches = 0;

    task automatic clear_tlv();
        tlv_pos   = '0;
        tlv_seq   = '0;
        tlv_mask  = '0;
        tlv_extra = 1'b0;
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
            mismatches++;
        end
    endtask

    // Advances the parser by one byte and queues the result it causes, if any.
    task automatic decode_tlv_byte(input r64tlv_pkg::t_in item);
        r64tlv_pkg::t_out             res;
        logic                         hit;
        logic [r64tlv_pkg::RID_W-1:0] rid;
        int                           r;
        res = '0;
        hit = 1'b0;
        rid = '0;
        if (tlv_pos == 0) begin
            tlv_seq   = item.data_byte;
            tlv_mask  = '0;
            tlv_extra = 1'b0;
            tlv_pos   = r64tlv_pkg::POS_W'(1);
        end else if (tlv_pos < r64tlv_pkg::HDR_END) begin
            // Mask byte k fills bits 63-8k..56-8k, so router 0 is bit 63.
            tlv_mask[r64tlv_pkg::MASK_W - 8 * int'(tlv_pos) +: 8] = item.data_byte;
            tlv_pos = tlv_pos + 1'b1;
        end else begin
            for (r = 0; r < r64tlv_pkg::MASK_W; r++) begin
                if (!hit && tlv_mask[r64tlv_pkg::MASK_W-1-r]) begin
                    hit = 1'b1;
                    rid = r64tlv_pkg::RID_W'(r);
                end
            end
            if (hit) begin
                tlv_mask[r64tlv_pkg::MASK_W-1-int'(rid)] = 1'b0;
            end else begin
                tlv_extra = 1'b1;
            end
        end

        if (hit || item.last) begin
            res.entry_valid = hit;
            if (hit) begin
                res.rtr_idx          = rid;
                res.outgoing_quality = item.data_byte[7:6];
                res.incoming_quality = item.data_byte[5:4];
                res.link_cost        = item.data_byte[3:0];
            end
            res.seq_id = tlv_seq;
            if (item.last) begin
                res.done_res = 1'b1;
                if (tlv_pos < r64tlv_pkg::HDR_END) begin
                    res.status = r64tlv_pkg::STATUS_TOO_SHORT;
                end else if (tlv_extra || tlv_mask != '0) begin
                    res.status = r64tlv_pkg::STATUS_MISMATCH;
                end else begin
                    res.status = r64tlv_pkg::STATUS_OK;
                end
                clear_tlv();
            end
            decoded_results_q.insert(decoded_results_q.size(), res);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_tlv();
            decoded_results_q.delete();
        end else begin
            // A result always stems from an earlier byte, so it is matched
            // before this edge's byte is modeled.
            if (i_out_valid && !i_out_stall) begin
                seen_result = i_out_data;
                if (decoded_results_q.size() == 0) begin
                    $display("%0t: result with none expected, expected none, actual %h",
                             $time, seen_result);
                    mismatches++;
                end else begin
                    want_result = decoded_results_q.pop_front();
                    check_field("entry_valid", 8'(want_result.entry_valid),
                                8'(seen_result.entry_valid));
                    check_field("rtr_idx", 8'(want_result.rtr_idx),
                                8'(seen_result.rtr_idx));
                    check_field("outgoing_quality", 8'(want_result.outgoing_quality),
                                8'(seen_result.outgoing_quality));
                    check_field("incoming_quality", 8'(want_result.incoming_quality),
                                8'(seen_result.incoming_quality));
                    check_field("link_cost", 8'(want_result.link_cost),
                                8'(seen_result.link_cost));
                    check_field("seq_id", want_result.seq_id,
                                seen_result.seq_id);
                    check_field("done_res", 8'(want_result.done_res),
                                8'(seen_result.done_res));
                    check_field("status", 8'(want_result.status),
                                8'(seen_result.status));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                decode_tlv_byte(i_in_data);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= decoded_results_q.size();
    end

endmodule

// ----- dv/route64_tlv_decoder_top_tb.sv -----
`timescale 1ns / 100ps
// ============================================================================
// route64_tlv_decoder_top_tb: stimulus and verdict for the TLV decoder
// Feeds whole Route64 TLV values byte by byte: a few hand-built ones first,
// then random ones, mostly well formed and some too short or with too few or
// too many route bytes. Both channels idle at random in two of three phases.
// A separate checker predicts and compares every result.
// ============================================================================
module route64_tlv_decoder_top_tb;

    typedef logic [7:0] t_byte_q[$];

    // Rough number of input bytes to send; the last TLV is always finished.
    localparam int N_ITEMS     = 500;
    // Cycles without any transaction on either channel before giving up.
    localparam int STALL_LIMIT = 2000;
    // Extra cycles after the last expected result, well above the latency.
    localparam int DRAIN_CYCLES = 8;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    r64tlv_pkg::t_in  i_in_data   = '0;
    logic             i_out_stall = 1'b0;
    logic             o_in_stall;
    logic             o_out_valid;
    r64tlv_pkg::t_out o_out_data;

    int fail_count;
    int pending_results;
    int items_sent    = 0;
    int idle_cycles   = 0;
    // Chances, in percent, that the sender idles before a byte and that the
    // receiver stalls in a given cycle.
    int src_idle_pct  = 0;
    int sink_stall_pct = 0;

    // 2 ns clock.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    route64_tlv_decoder_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    route64_tlv_decoder_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    // The receiver stalls at random; a new decision is made every cycle, so
    // stalls land on every stage of the decoder's work.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
    end

    // Watchdog: any transaction on either channel restarts the count. A hung
    // handshake or a result that never comes ends the run here.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Sends the bytes of one TLV value in order, marking the final one as
    // last. Inputs change at the falling edge; a byte is taken at the first
    // rising edge with valid high and stall low, and it is held until then.
    task automatic send_tlv_bytes(input t_byte_q tlv_bytes);
        r64tlv_pkg::t_in item;
        int              idx;
        for (idx = 0; idx < tlv_bytes.size(); idx++) begin
            item.data_byte = tlv_bytes[idx];
            item.last      = (idx == tlv_bytes.size() - 1);
            @(negedge i_clk);
            while ($urandom_range(0, 99) < src_idle_pct) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
            i_in_valid <= 1'b1;
            i_in_data  <= item;
            @(posedge i_clk);
            while (o_in_stall) begin
                @(posedge i_clk);
            end
            items_sent++;
        end
    endtask

    // Builds one random TLV value. Most carry as many route bytes as the mask
    // has set bits; the rest stop inside the header, or carry too few or too
    // many route bytes. Masks are mostly sparse so that TLVs stay short, with
    // an occasional full, empty or dense mask.
    task automatic send_random_tlv();
        t_byte_q                       tlv_bytes;
        logic [r64tlv_pkg::MASK_W-1:0] router_mask;
        int                            mask_pick;
        int                            shape_pick;
        int                            n_routers;
        int                            n_route_bytes;
        int                            keep_bytes;
        int                            k;
        mask_pick   = $urandom_range(0, 99);
        router_mask = '0;
        if (mask_pick < 4) begin
            router_mask = '1;
        end else if (mask_pick < 10) begin
            router_mask = '0;
        end else if (mask_pick < 16) begin
            router_mask = {$urandom, $urandom};
        end else begin
            repeat ($urandom_range(1, 6)) begin
                router_mask[$urandom_range(0, r64tlv_pkg::MASK_W - 1)] = 1'b1;
            end
        end
        n_routers = $countones(router_mask);

        shape_pick    = $urandom_range(0, 99);
        n_route_bytes = n_routers;
        keep_bytes    = 0;
        if (shape_pick >= 72 && shape_pick < 84) begin
            // Too few route bytes, down to none at all.
            n_route_bytes = (n_routers > 0) ? $urandom_range(0, n_routers - 1) : 0;
        end else if (shape_pick >= 84 && shape_pick < 93) begin
            // Route bytes left over once the mask is used up.
            n_route_bytes = n_routers + $urandom_range(1, 3);
        end else if (shape_pick >= 93) begin
            // Last arrives before the mask is complete.
            keep_bytes = $urandom_range(1, r64tlv_pkg::MASK_BYTES);
        end

        tlv_bytes.insert(tlv_bytes.size(), 8'($urandom_range(0, 255)));
        for (k = 0; k < r64tlv_pkg::MASK_BYTES; k++) begin
            tlv_bytes.insert(tlv_bytes.size(),
                             router_mask[r64tlv_pkg::MASK_W - 1 - 8 * k -: 8]);
        end
        repeat (n_route_bytes) begin
            tlv_bytes.insert(tlv_bytes.size(), 8'($urandom_range(0, 255)));
        end
        if (keep_bytes > 0) begin
            while (tlv_bytes.size() > keep_bytes) begin
                void'(tlv_bytes.pop_back());
            end
        end
        send_tlv_bytes(tlv_bytes);
    endtask

    initial begin
        t_byte_q tlv_bytes;

        // First phase: the sender idles now and then, the receiver often.
        src_idle_pct   = 12;
        sink_stall_pct = 52;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A one-byte TLV: too short, with the largest ID sequence.
        tlv_bytes = {8'hFF};
        send_tlv_bytes(tlv_bytes);
        // Ends partway through the mask: too short.
        tlv_bytes = {8'h3C, 8'h12, 8'h34};
        send_tlv_bytes(tlv_bytes);
        // Routers 0 and 63 only, with all-ones and all-zeros route bytes:
        // a good TLV that pairs the first and the last mask bit.
        tlv_bytes = {8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h01, 8'hFF, 8'h00};
        send_tlv_bytes(tlv_bytes);
        // Empty mask followed by a route byte: no entry, length mismatch.
        tlv_bytes = {8'hA5, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                     8'h00, 8'h5A};
        send_tlv_bytes(tlv_bytes);

        // Random TLVs. The idle rates swap after a third of the bytes, and
        // the last third runs with no idling on either side.
        while (items_sent < N_ITEMS) begin
            if (items_sent < N_ITEMS / 3) begin
                src_idle_pct   = 12;
                sink_stall_pct = 52;
            end else if (items_sent < 2 * N_ITEMS / 3) begin
                src_idle_pct   = 52;
                sink_stall_pct = 12;
            end else begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
            end
            send_random_tlv();
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Wait for every predicted result; the watchdog bounds this wait.
        while (pending_results != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_results == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
